>>> sv/video_frame_dma_burst_generator_defines.svh
// ----------------------------------------------------------------------------
// video frame dma burst generator assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef VIDEO_FRAME_DMA_BURST_GENERATOR_DEFINES_SVH
`define VIDEO_FRAME_DMA_BURST_GENERATOR_DEFINES_SVH

// same-cycle implication
`define VFDBG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VFDBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/vfdbg_pkg.sv
// ----------------------------------------------------------------------------
// vfdbg_pkg
// shared constants, register indexes and types of the burst generator
// ----------------------------------------------------------------------------
package vfdbg_pkg;

  localparam int MAX_BURST_BYTES = 512;
  localparam int MAX_PKT_BYTES   = 1024;
  localparam int MAX_BURSTS      = 64;
  localparam int NUM_FRAMES      = 6;
  localparam int QUEUE_DEPTH     = 4;

  localparam int BURST_W = $clog2(MAX_BURST_BYTES + 1);
  localparam int COUNT_W = $clog2(MAX_BURSTS + 1);
  localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_FILL  = 1'b1;

  localparam logic [2:0] REG_H_BLANK      = 3'd0;
  localparam logic [2:0] REG_H_TOTAL      = 3'd1;
  localparam logic [2:0] REG_V_BLANK      = 3'd2;
  localparam logic [2:0] REG_V_TOTAL      = 3'd3;
  localparam logic [2:0] REG_FRAME_STRIDE = 3'd4;

  typedef struct packed {
    logic [10:0] h_blank;
    logic [11:0] h_total;
    logic [5:0]  v_blank;
    logic [9:0]  v_total;
    logic [23:0] frame_stride;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  frame_index;
    logic [17:0] buffer_addr;
    logic [10:0] pkt_len;
  } cmd_t;

  typedef struct packed {
    logic        burst_valid;
    logic [6:0]  burst_words_m1;
    logic [15:0] int_word_addr;
    logic [21:0] ext_word_addr;
    logic [10:0] bytes_consumed;
    logic        frame_done;
    logic        last;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> sv/vfdbg_front.sv
// ----------------------------------------------------------------------------
// vfdbg_front
// input side: takes items, drops starts of absent frames, saturates lengths
// ----------------------------------------------------------------------------
module vfdbg_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  vfdbg_pkg::cmd_t     s_cmd,
  input  vfdbg_pkg::qstat_t   q_stat,
  output logic                q_push,
  output vfdbg_pkg::cmd_t     q_cmd
);
  import vfdbg_pkg::*;

  logic take;
  logic bad_frame;

  assign s_tready  = !q_stat.full;
  assign take      = s_tvalid && s_tready;
  assign bad_frame = (s_cmd.kind == KIND_START) && (int'(s_cmd.frame_index) >= NUM_FRAMES);
  assign q_push    = take && !bad_frame;

  always_comb begin
    q_cmd = s_cmd;
    if (int'(s_cmd.pkt_len) > MAX_PKT_BYTES) begin
      q_cmd.pkt_len = 11'(MAX_PKT_BYTES);
    end
  end

endmodule

>>> sv/vfdbg_queue.sv
// ----------------------------------------------------------------------------
// vfdbg_queue
// short command queue between the front and the burst engine, show-ahead
// ----------------------------------------------------------------------------
module vfdbg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vfdbg_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output vfdbg_pkg::cmd_t   head,
  output vfdbg_pkg::qstat_t stat
);
  import vfdbg_pkg::*;

  cmd_t               entries [QUEUE_DEPTH];
  logic [QADDR_W-1:0] wr_ptr;
  logic [QADDR_W-1:0] rd_ptr;
  logic [QADDR_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count == (QADDR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/vfdbg_back.sv
// ----------------------------------------------------------------------------
// vfdbg_back
// burst engine: frame position state, burst sizing and the result register
// ----------------------------------------------------------------------------
`include "video_frame_dma_burst_generator_defines.svh"

module vfdbg_back (
  input  logic              clk,
  input  logic              rst,
  input  vfdbg_pkg::cfg_t   cfg,
  input  vfdbg_pkg::cmd_t   head,
  input  vfdbg_pkg::qstat_t q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output vfdbg_pkg::res_t   out_res
);
  import vfdbg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_STEP
  } state_t;

  state_t             state;
  logic [23:0]        frame_base;
  logic [11:0]        pos_x;
  logic [9:0]         pos_y;
  logic               finished;
  logic [10:0]        left_r;
  logic [17:0]        ptr_r;
  logic [10:0]        used_r;
  logic [COUNT_W-1:0] n_r;
  logic [BURST_W-1:0] b_r;
  logic [21:0]        prod_r;
  res_t               pend;
  logic               pend_valid;

  logic [26:0]        base_prod;
  logic [12:0]        line_bytes;
  logic [12:0]        lim_pkt;
  logic [12:0]        lim_all;
  logic [BURST_W-1:0] b_calc;
  logic [11:0]        x_adv;
  logic [9:0]         y_inc;
  logic               wrap;
  logic               fin_next;
  logic [10:0]        used_next;
  logic [22:0]        line_pix;
  logic [23:0]        ext_addr;
  logic [7:0]         words;
  logic               out_free;
  logic               stop;
  logic               issue;
  logic               out_burst;
  logic               out_nonburst;
  logic               fill_pop;
  res_t               burst_res;
  res_t               empty_res;
  res_t               pend_last;

  assign q_pop     = (state == S_IDLE) && !q_stat.empty;
  assign base_prod = 27'(head.frame_index) * 27'(cfg.frame_stride);

  always_comb begin
    line_bytes = (pos_x < cfg.h_total) ? {cfg.h_total - pos_x, 1'b0} : 13'd0;
    lim_pkt    = (line_bytes < {2'b00, left_r}) ? line_bytes : {2'b00, left_r};
    lim_all    = (lim_pkt < 13'(MAX_BURST_BYTES)) ? lim_pkt : 13'(MAX_BURST_BYTES);
    b_calc     = BURST_W'(lim_all & ~13'd3);
  end

  assign x_adv     = pos_x + 12'(b_r >> 1);
  assign wrap      = (x_adv == cfg.h_total);
  assign y_inc     = pos_y + 10'd1;
  assign fin_next  = wrap && (y_inc == cfg.v_total);
  assign used_next = used_r + 11'(b_r);
  assign line_pix  = {1'b0, prod_r} + {11'b0, pos_x};
  assign ext_addr  = frame_base + {line_pix, 1'b0};
  assign words     = 8'(b_r >> 2) - 8'd1;
  assign out_free  = !out_valid || out_ready;
  assign stop      = finished || (n_r >= COUNT_W'(MAX_BURSTS)) || (b_r == '0);
  assign issue     = (state == S_STEP) && out_free && (pend_valid || finished || (b_r == '0));

  assign out_burst    = out_valid && out_res.burst_valid;
  assign out_nonburst = out_valid && !out_res.burst_valid;
  assign fill_pop     = q_pop && (head.kind == KIND_FILL);

  always_comb begin
    burst_res.burst_valid    = 1'b1;
    burst_res.burst_words_m1 = words[6:0];
    burst_res.int_word_addr  = ptr_r[17:2];
    burst_res.ext_word_addr  = ext_addr[23:2];
    burst_res.bytes_consumed = used_next;
    burst_res.frame_done     = fin_next;
    burst_res.last           = 1'b0;
    empty_res                = '0;
    empty_res.frame_done     = finished;
    empty_res.last           = 1'b1;
    pend_last                = pend;
    pend_last.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      frame_base <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
      finished   <= 1'b1;
      n_r        <= '0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            if (head.kind == KIND_START) begin
              frame_base <= base_prod[23:0];
              pos_x      <= {1'b0, cfg.h_blank};
              pos_y      <= {4'b0, cfg.v_blank};
              finished   <= 1'b0;
            end else begin
              left_r     <= head.pkt_len;
              ptr_r      <= head.buffer_addr;
              used_r     <= '0;
              n_r        <= '0;
              pend_valid <= 1'b0;
              state      <= S_CALC;
            end
          end
        end
        S_CALC: begin
          b_r    <= b_calc;
          prod_r <= 22'(pos_y) * 22'(cfg.h_total);
          state  <= S_STEP;
        end
        S_STEP: begin
          if (out_free) begin
            if (pend_valid && stop) begin
              out_res    <= pend_last;
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end else if (!pend_valid && (finished || (b_r == '0))) begin
              out_res   <= empty_res;
              state     <= S_IDLE;
            end else begin
              if (pend_valid) begin
                out_res   <= pend;
              end
              // next burst waits here until the one after it is sized
              pend       <= burst_res;
              pend_valid <= 1'b1;
              left_r     <= left_r - 11'(b_r);
              ptr_r      <= ptr_r + 18'(b_r);
              used_r     <= used_next;
              n_r        <= n_r + 1'b1;
              if (wrap) begin
                pos_x    <= {1'b0, cfg.h_blank};
                pos_y    <= y_inc;
                finished <= fin_next;
              end else begin
                pos_x    <= x_adv;
              end
              state      <= S_CALC;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VFDBG_ASSERT_NOW(a_burst_bytes, out_burst, out_res.bytes_consumed != '0, "zero-byte burst")
  `VFDBG_ASSERT_NOW(a_empty_is_last, out_nonburst, out_res.last, "non-burst result not last")
  `VFDBG_ASSERT_NOW(a_burst_count, 1'b1, n_r <= COUNT_W'(MAX_BURSTS), "burst count beyond limit")
  `VFDBG_ASSERT_NOW(a_idle_no_pending, state == S_IDLE, !pend_valid, "pending burst in idle")
  `VFDBG_ASSERT_NEXT(a_fill_starts, fill_pop, (state == S_CALC) && (n_r == '0), "fill not sizing")

endmodule

>>> sv/video_frame_dma_burst_generator.sv
// burst loop: size, then address and issue; issue holds while the result is stalled
// commands are popped only in idle; a queue of 4 commands decouples the input side
// reset: synchronous, clears queue, engine and result valid flag; the frame reads as finished
// ----------------------------------------------------------------------------
// video_frame_dma_burst_generator
// frame read-out dma burst generator: front side, command queue, burst engine
// ----------------------------------------------------------------------------
module video_frame_dma_burst_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // frame_index, buffer_addr, pkt_len
  input  logic [0:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // burst_words_m1, int_word_addr, ext_word_addr,
                                     // bytes_consumed, frame_done, zero pad
  output logic [0:0]  m_axis_tuser,  // burst_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import vfdbg_pkg::*;

  cfg_t   cfg;
  cmd_t   s_cmd;
  cmd_t   q_cmd;
  cmd_t   head;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  res_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.h_blank      <= 11'd144;
      cfg.h_total      <= 12'd2048;
      cfg.v_blank      <= 6'd0;
      cfg.v_total      <= 10'd1023;
      cfg.frame_stride <= 24'd1179648;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_H_BLANK:      cfg.h_blank      <= cfg_data[10:0];
        REG_H_TOTAL:      cfg.h_total      <= cfg_data[11:0];
        REG_V_BLANK:      cfg.v_blank      <= cfg_data[5:0];
        REG_V_TOTAL:      cfg.v_total      <= cfg_data[9:0];
        REG_FRAME_STRIDE: cfg.frame_stride <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_cmd.kind        = s_axis_tuser[0];
  assign s_cmd.frame_index = s_axis_tdata[2:0];
  assign s_cmd.buffer_addr = s_axis_tdata[20:3];
  assign s_cmd.pkt_len     = s_axis_tdata[31:21];

  vfdbg_front u_front (
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_cmd    (s_cmd),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  vfdbg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  vfdbg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {7'b0, res.frame_done, res.bytes_consumed, res.ext_word_addr,
                         res.int_word_addr, res.burst_words_m1};
  assign m_axis_tuser = res.burst_valid;
  assign m_axis_tlast = res.last;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the frame read-out dma burst generator: every
// accepted start or fill item runs through a local model of the read position
// and the packet split, and each transfer on the result side is checked
// against the oldest predicted result, field by field
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vfdbg_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // frame_index, buffer_addr, pkt_len
  logic [0:0]  s_axis_tuser = '0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // burst_words_m1, int_word_addr, ext_word_addr,
                                   // bytes_consumed, frame_done, zero pad
  logic [0:0]  m_axis_tuser;       // burst_valid
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  video_frame_dma_burst_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  cfg_t        regs = '{h_blank: 11'd144, h_total: 12'd2048, v_blank: 6'd0,
                        v_total: 10'd1023, frame_stride: 24'd1179648};
  logic [23:0] frame_base = '0;
  logic [11:0] pos_x = '0;
  logic [9:0]  pos_y = '0;
  bit          frame_finished = 1'b1;

  res_t pending_bursts[$];
  int   mismatches = 0;
  int   send_idle_pct = 18;
  int   recv_idle_pct = 86;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic int unsigned burst_bytes(int unsigned remaining);
    int unsigned b;
    b = (pos_x < regs.h_total) ? 2 * (int'(regs.h_total) - int'(pos_x)) : 0;
    if (b > remaining) b = remaining;
    if (b > MAX_BURST_BYTES) b = MAX_BURST_BYTES;
    return b & ~32'd3;
  endfunction

  function automatic void plan_bursts(logic [17:0] buf_addr, logic [10:0] pkt_len);
    int unsigned remaining, ptr, used, nbytes, ext, count;
    bit stop;
    res_t r;
    remaining = (pkt_len > MAX_PKT_BYTES) ? MAX_PKT_BYTES : pkt_len;
    ptr = 32'(buf_addr);
    used = 0;
    count = 0;
    nbytes = frame_finished ? 0 : burst_bytes(remaining);
    if (nbytes == 0) begin
      r = '0;
      r.frame_done = frame_finished;
      r.last = 1'b1;
      pending_bursts.push_back(r);
    end else begin
      stop = 1'b0;
      while (!stop) begin
        ext = frame_base + 2 * (int'(pos_y) * int'(regs.h_total) + int'(pos_x));
        r = '0;
        r.burst_valid = 1'b1;
        r.burst_words_m1 = 7'((nbytes >> 2) - 1);
        r.int_word_addr = 16'(ptr >> 2);
        r.ext_word_addr = 22'(ext >> 2);
        remaining -= nbytes;
        ptr += nbytes;
        used += nbytes;
        pos_x = 12'(pos_x + nbytes / 2);
        if (pos_x == regs.h_total) begin
          pos_x = {1'b0, regs.h_blank};
          pos_y = pos_y + 1'b1;
          if (pos_y == regs.v_total) frame_finished = 1'b1;
        end
        count++;
        r.bytes_consumed = 11'(used);
        r.frame_done = frame_finished;
        stop = frame_finished || count >= MAX_BURSTS;
        if (!stop) begin
          nbytes = burst_bytes(remaining);
          stop = (nbytes == 0);
        end
        r.last = stop;
        pending_bursts.push_back(r);
      end
    end
  endfunction

  task automatic send_item(logic kind, logic [2:0] fidx, logic [17:0] addr,
                           logic [10:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {len, addr, fidx};
    do @(posedge clk); while (!s_axis_tready);
    if (kind == KIND_START) begin
      if (fidx < NUM_FRAMES) begin
        frame_base = fidx * regs.frame_stride;
        pos_x = {1'b0, regs.h_blank};
        pos_y = {4'b0, regs.v_blank};
        frame_finished = 1'b0;
      end
    end else begin
      plan_bursts(addr, len);
    end
  endtask

  // also lets queued start items clear the engine
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_bursts.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_H_BLANK:      regs.h_blank = data[10:0];
      REG_H_TOTAL:      regs.h_total = data[11:0];
      REG_V_BLANK:      regs.v_blank = data[5:0];
      REG_V_TOTAL:      regs.v_total = data[9:0];
      REG_FRAME_STRIDE: regs.frame_stride = data;
      default: ;
    endcase
  endtask

  task automatic set_config(cfg_t c);
    wait_drained();
    write_reg(REG_H_BLANK, 24'(c.h_blank));
    write_reg(REG_H_TOTAL, 24'(c.h_total));
    write_reg(REG_V_BLANK, 24'(c.v_blank));
    write_reg(REG_V_TOTAL, 24'(c.v_total));
    write_reg(REG_FRAME_STRIDE, c.frame_stride);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bursts.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected transfer, expected none actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_bursts.pop_front();
        check_field("burst_valid", 32'(want.burst_valid), 32'(m_axis_tuser[0]));
        check_field("burst_words_m1", 32'(want.burst_words_m1), 32'(m_axis_tdata[6:0]));
        check_field("int_word_addr", 32'(want.int_word_addr), 32'(m_axis_tdata[22:7]));
        check_field("ext_word_addr", 32'(want.ext_word_addr), 32'(m_axis_tdata[44:23]));
        check_field("bytes_consumed", 32'(want.bytes_consumed), 32'(m_axis_tdata[55:45]));
        check_field("frame_done", 32'(want.frame_done), 32'(m_axis_tdata[56]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // no frame running yet
  task automatic test_idle_frame();
    send_item(KIND_FILL, 3'd0, 18'h0, 11'd1024);
    send_item(KIND_START, 3'd6, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h100, 11'd64);
  endtask

  task automatic test_packet_sizes();
    send_item(KIND_START, 3'd0, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h0, 11'd1024);
    send_item(KIND_FILL, 3'd7, 18'h3ffff, 11'd2047);
    send_item(KIND_FILL, 3'd0, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h5, 11'd3);
    send_item(KIND_FILL, 3'd0, 18'h0, 11'd7);
    send_item(KIND_START, 3'd7, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h1234, 11'd1024);
  endtask

  task automatic test_base_address();
    wait_drained();
    write_reg(REG_FRAME_STRIDE, 24'hffffff);
    cfg_we <= 1'b0;
    send_item(KIND_START, 3'd5, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h2a000, 11'd512);
    wait_drained();
    write_reg(REG_FRAME_STRIDE, 24'h0);
    cfg_we <= 1'b0;
    send_item(KIND_START, 3'd3, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h10, 11'd100);
  endtask

  task automatic test_frame_end();
    set_config('{h_blank: 11'd0, h_total: 12'd8, v_blank: 6'd0, v_total: 10'd2,
                 frame_stride: 24'd1000});
    send_item(KIND_START, 3'd1, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h40, 11'd1024);
    send_item(KIND_FILL, 3'd0, 18'h80, 11'd1024);
  endtask

  task automatic test_burst_cap();
    set_config('{h_blank: 11'd2, h_total: 12'd6, v_blank: 6'd1, v_total: 10'd1023,
                 frame_stride: 24'h123456});
    send_item(KIND_START, 3'd4, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h20000, 11'd1024);
  endtask

  // odd line length leaves two bytes at the line end
  task automatic test_short_line_end();
    set_config('{h_blank: 11'd0, h_total: 12'd7, v_blank: 6'd0, v_total: 10'd4,
                 frame_stride: 24'd4096});
    send_item(KIND_START, 3'd0, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h300, 11'd100);
    send_item(KIND_FILL, 3'd0, 18'h400, 11'd100);
  endtask

  task automatic test_bad_geometry();
    wait_drained();
    write_reg(REG_H_BLANK, 24'hffffff);
    write_reg(REG_H_TOTAL, 24'd2048);
    write_reg(REG_UNUSED, 24'h5a5a5a);
    cfg_we <= 1'b0;
    send_item(KIND_START, 3'd0, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h0, 11'd1024);
    wait_drained();
    write_reg(REG_H_BLANK, 24'd10);
    write_reg(REG_H_TOTAL, 24'hfff008);
    cfg_we <= 1'b0;
    send_item(KIND_START, 3'd2, 18'h0, 11'd0);
    send_item(KIND_FILL, 3'd0, 18'h0, 11'd1024);
  endtask

  // start line above the end line: the line count runs through 1023 and wraps
  task automatic test_line_counter_wrap();
    int guard;
    set_config('{h_blank: 11'd0, h_total: 12'd2, v_blank: 6'd5, v_total: 10'd3,
                 frame_stride: 24'hffffff});
    send_item(KIND_START, 3'd2, 18'h0, 11'd0);
    guard = 0;
    while (!frame_finished && guard < 24) begin
      send_item(KIND_FILL, 3'd0, 18'($urandom), 11'd1024);
      guard++;
    end
    send_item(KIND_FILL, 3'd0, 18'($urandom), 11'd1024);
  endtask

  task automatic random_setting();
    cfg_t c;
    if ($urandom_range(0, 99) < 25) c.h_total = 12'($urandom_range(1, 1024) * 2);
    else c.h_total = 12'($urandom_range(1, 64) * 2);
    if ($urandom_range(0, 9) == 0) c.h_total = c.h_total | 12'd1;
    if ($urandom_range(0, 9) == 0) c.h_blank = 11'($urandom);
    else c.h_blank = 11'($urandom_range(0, c.h_total - 1));
    c.v_blank = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) c.v_total = 10'($urandom);
    else c.v_total = 10'(c.v_blank + $urandom_range(1, 6));
    c.frame_stride = 24'($urandom);
    set_config(c);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    int sent;
    int pick;
    logic [2:0] fidx;
    logic [10:0] len;
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_setting();
    sent = 0;
    while (sent < n_items) begin
      send_item(KIND_START, 3'($urandom_range(0, NUM_FRAMES - 1)), 18'($urandom),
                11'($urandom));
      sent++;
      repeat ($urandom_range(1, 16)) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          fidx = 3'($urandom_range(0, 7));
          send_item(KIND_START, fidx, 18'($urandom), 11'($urandom));
          if (fidx < NUM_FRAMES) sent++;
        end else begin
          if (pick < 60) len = 11'($urandom_range(1, 256) * 4);
          else if (pick < 80) len = 11'($urandom_range(0, 1024));
          else if (pick < 90) len = 11'($urandom_range(0, 7));
          else len = 11'($urandom_range(1025, 2047));
          send_item(KIND_FILL, 3'($urandom), 18'($urandom), len);
          sent++;
        end
      end
      if ($urandom_range(0, 24) == 0) wait_drained();
      if ($urandom_range(0, 4) == 0) random_setting();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_frame();
    test_packet_sizes();
    test_base_address();
    test_frame_end();
    test_burst_cap();
    test_short_line_end();
    test_bad_geometry();
    test_line_counter_wrap();
    test_random_traffic(18, 86, 120);
    test_random_traffic(86, 18, 120);
    test_random_traffic(0, 0, 120);
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
